[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the discrete-log block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising edge, held off while reset is low.
`define PHDL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define PHDL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PHDL_ASSERT(lbl, clk, rstn, prop, msg)
`define PHDL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/phdl_pkg.sv]
// Package: types, codes and defaults of the discrete-log block.
`timescale 1ns / 1ps
`default_nettype none
package phdl_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int MAX_FACTORS_DEF = 16;
    localparam int MAX_PRIME_DEF   = 128;

    localparam int TARGET_BITS = 32;
    localparam int LOG_BITS    = 32;
    localparam int STATUS_BITS = 2;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [31:0] MODULUS_RESET   = 32'd3;
    localparam logic [31:0] GENERATOR_RESET = 32'd2;

    localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_BOUND   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_NODIGIT = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MODULUS   = 1'b0,
        REG_GENERATOR = 1'b1
    } reg_idx_t;

    typedef enum logic {
        ALU_MULMOD = 1'b0,
        ALU_DIV    = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RED_B,
        ST_RED_Y,
        ST_TD_CHK,
        ST_TD_FIRST,
        ST_TD_MORE,
        ST_FAC,
        ST_G,
        ST_TBL0,
        ST_TBL,
        ST_TBL_W,
        ST_DG_CHK,
        ST_DG_DIV,
        ST_DG_PROBE,
        ST_SR_RD,
        ST_SR_CMP,
        ST_DG_ACC,
        ST_DG_H,
        ST_DG_K,
        ST_DG_Y,
        ST_DG_NEXT,
        ST_CRT_REM,
        ST_CRT_R1,
        ST_INV_CHK,
        ST_INV_Q,
        ST_INV_T,
        ST_CRT_V,
        ST_CRT_TERM,
        ST_TD_END,
        ST_FIN,
        ST_ALU_WAIT,
        ST_PW_CHK,
        ST_PW_MUL,
        ST_PW_SQ,
        ST_PW_SQD
    } state_t;

endpackage
`default_nettype wire

[rtl/phdl_alu.sv]
// Shared bit-serial unit: modular multiply and restoring divide.
`timescale 1ns / 1ps
`default_nettype none
module phdl_alu #(
    parameter int W = phdl_pkg::VALUE_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire phdl_pkg::alu_req_t req,
    input  wire logic [W-1:0]      a,
    input  wire logic [W-1:0]      b,
    input  wire logic [W-1:0]      m,
    output phdl_pkg::alu_stat_t    stat,
    output logic [W-1:0]           res,
    output logic [W-1:0]           quo
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    phdl_pkg::alu_op_t op_reg, op_next;
    logic [W:0]   acc_reg, acc_next;
    logic [W-1:0] sh_reg, sh_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] m_reg, m_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [W:0] t;
    logic [W:0] m_ext;
    logic       last;

    always_comb begin
        op_next    = op_reg;
        acc_next   = acc_reg;
        sh_next    = sh_reg;
        a_next     = a_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        m_ext      = {1'b0, m_reg};
        t          = '0;
        last       = (cnt_reg == '0);
        if (req.start) begin
            op_next    = req.op;
            acc_next   = '0;
            sh_next    = b;
            a_next     = a;
            m_next     = m;
            cnt_next   = CW'(W - 1);
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            unique case (op_reg)
                phdl_pkg::ALU_MULMOD: begin
                    if (!phase_reg) begin
                        // double and fold back below m
                        t = {acc_reg[W-1:0], 1'b0};
                        if (t >= m_ext) t = t - m_ext;
                        acc_next   = t;
                        phase_next = 1'b1;
                    end else begin
                        // add a if the multiplier bit is set
                        t = acc_reg + (sh_reg[W-1] ? {1'b0, a_reg} : '0);
                        if (t >= m_ext) t = t - m_ext;
                        acc_next   = t;
                        sh_next    = {sh_reg[W-2:0], 1'b0};
                        phase_next = 1'b0;
                        cnt_next   = cnt_reg - 1'b1;
                        if (last) begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                end
                phdl_pkg::ALU_DIV: begin
                    t = {acc_reg[W-1:0], sh_reg[W-1]};
                    if (t >= m_ext) begin
                        acc_next = t - m_ext;
                        sh_next  = {sh_reg[W-2:0], 1'b1};
                    end else begin
                        acc_next = t;
                        sh_next  = {sh_reg[W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                    if (last) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        sh_reg    <= sh_next;
        a_reg     <= a_next;
        m_reg     <= m_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res = acc_reg[W-1:0];
    assign quo = sh_reg;

endmodule
`default_nettype wire

[rtl/pohlig_hellman_discrete_log.sv]
// Top level: Pohlig-Hellman discrete logarithm sequencer around one shared unit.
// Work: pow_mod up to 2*VALUE_BITS multiplies; a query: up to MAX_PRIME-1 trial divides, per
//   prime power d^e a pow_mod and d-1 multiplies, per digit a divide, a probe pow_mod, a search
//   of up to d table entries and, if the digit is nonzero, 2 pow_mods and a multiply, then CRT.
// Throughput: one word per query; no new word is taken until the result is in the output register.
// Reset: synchronous, active low; modulus returns to 3, generator to 2, channels go empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pohlig_hellman_discrete_log #(
    parameter int VALUE_BITS  = phdl_pkg::VALUE_BITS_DEF,
    parameter int MAX_FACTORS = phdl_pkg::MAX_FACTORS_DEF,
    parameter int MAX_PRIME   = phdl_pkg::MAX_PRIME_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [phdl_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
    input  wire logic [phdl_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [phdl_pkg::TARGET_BITS-1:0]   s_target,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [phdl_pkg::LOG_BITS-1:0]           m_log_value,
    output logic [phdl_pkg::STATUS_BITS-1:0]        m_status
);

    localparam int VB = VALUE_BITS;
    localparam int FB = $clog2(MAX_PRIME + 2);   // trial divisor runs to MAX_PRIME+1
    localparam int AW = $clog2(MAX_PRIME);
    localparam int CB = $clog2(MAX_FACTORS + 1);

    // Configuration registers
    logic [VB-1:0] mod_cfg_reg, gen_cfg_reg;

    // Sequencer state
    phdl_pkg::state_t state_reg, state_next;
    phdl_pkg::state_t ret_reg, ret_next;        // return point after a unit call
    phdl_pkg::state_t pw_ret_reg, pw_ret_next;  // return point after a pow_mod

    // Query datapath
    logic [VB-1:0] tgt_reg, tgt_next;
    logic [VB-1:0] p_reg, p_next;
    logic [VB-1:0] n_reg, n_next;
    logic [VB-1:0] b_reg, b_next;
    logic [VB-1:0] y0_reg, y0_next;
    logic [VB-1:0] y_reg, y_next;
    logic [VB-1:0] rest_reg, rest_next;
    logic [FB-1:0] f_reg, f_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [VB-1:0] dd_reg, dd_next;
    logic [VB-1:0] dpow_reg, dpow_next;
    logic [VB-1:0] dd1_reg, dd1_next;
    logic [VB-1:0] acc_reg, acc_next;
    logic [VB-1:0] g_reg, g_next;
    logic [VB-1:0] tv_reg, tv_next;
    logic [FB-1:0] idx_reg, idx_next;
    logic [FB-1:0] digit_reg, digit_next;
    logic          miss_reg, miss_next;
    logic [VB-1:0] x_reg, x_next;
    logic [VB-1:0] rem_reg, rem_next;
    logic [VB-1:0] r0_reg, r0_next;
    logic [VB-1:0] r1_reg, r1_next;
    logic [VB-1:0] t0_reg, t0_next;
    logic [VB-1:0] t1_reg, t1_next;
    logic [VB-1:0] inv_reg, inv_next;
    logic [VB-1:0] pw_r_reg, pw_r_next;
    logic [VB-1:0] pw_s_reg, pw_s_next;
    logic [VB-1:0] pw_e_reg, pw_e_next;
    logic [VB-1:0] out_log_reg, out_log_next;
    logic [phdl_pkg::STATUS_BITS-1:0] out_st_reg, out_st_next;

    // Output register
    logic                             m_valid_reg, m_valid_next;
    logic [VB-1:0]                    m_log_reg, m_log_next;
    logic [phdl_pkg::STATUS_BITS-1:0] m_st_reg, m_st_next;

    // Digit table memory
    logic [VB-1:0] tbl_mem [MAX_PRIME];
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [VB-1:0] tbl_wdata;
    logic [VB-1:0] tbl_rd_reg;

    // Shared unit
    phdl_pkg::alu_req_t  alu_req;
    phdl_pkg::alu_stat_t alu_stat;
    logic [VB-1:0] alu_a, alu_b, alu_m, alu_res, alu_quo;

    logic accept;
    logic out_free;
    logic [VB:0] sum_x;
    logic [VB:0] t_diff;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == phdl_pkg::ST_IDLE);

    phdl_alu #(
        .W(VB)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .m      (alu_m),
        .stat   (alu_stat),
        .res    (alu_res),
        .quo    (alu_quo)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_cfg_reg <= phdl_pkg::MODULUS_RESET[VB-1:0];
            gen_cfg_reg <= phdl_pkg::GENERATOR_RESET[VB-1:0];
        end else if (cfg_we) begin
            unique case (phdl_pkg::reg_idx_t'(cfg_idx))
                phdl_pkg::REG_MODULUS:   mod_cfg_reg <= cfg_wdata[VB-1:0];
                phdl_pkg::REG_GENERATOR: gen_cfg_reg <= cfg_wdata[VB-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            phdl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (mod_cfg_reg < VB'(3)) state_next = phdl_pkg::ST_FIN;
                    else                      state_next = phdl_pkg::ST_ALU_WAIT;
                end
            end
            phdl_pkg::ST_RED_B:  state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_RED_Y:  state_next = phdl_pkg::ST_TD_CHK;
            phdl_pkg::ST_TD_CHK: begin
                if (f_reg > FB'(MAX_PRIME) || rest_reg <= VB'(1))
                    state_next = phdl_pkg::ST_TD_END;
                else
                    state_next = phdl_pkg::ST_ALU_WAIT;
            end
            phdl_pkg::ST_TD_FIRST: begin
                if (alu_res != '0)                      state_next = phdl_pkg::ST_TD_CHK;
                else if (cnt_reg >= CB'(MAX_FACTORS))  state_next = phdl_pkg::ST_FIN;
                else                                    state_next = phdl_pkg::ST_ALU_WAIT;
            end
            phdl_pkg::ST_TD_MORE: begin
                if (alu_res == '0) state_next = phdl_pkg::ST_ALU_WAIT;
                else               state_next = phdl_pkg::ST_FAC;
            end
            phdl_pkg::ST_FAC:      state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_G:        state_next = phdl_pkg::ST_PW_CHK;
            phdl_pkg::ST_TBL0:     state_next = phdl_pkg::ST_TBL;
            phdl_pkg::ST_TBL: begin
                if (idx_reg < f_reg) state_next = phdl_pkg::ST_ALU_WAIT;
                else                 state_next = phdl_pkg::ST_DG_CHK;
            end
            phdl_pkg::ST_TBL_W:    state_next = phdl_pkg::ST_TBL;
            phdl_pkg::ST_DG_CHK: begin
                if (dpow_reg == dd_reg) state_next = phdl_pkg::ST_ALU_WAIT;
                else                    state_next = phdl_pkg::ST_DG_DIV;
            end
            phdl_pkg::ST_DG_DIV:   state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_DG_PROBE: state_next = phdl_pkg::ST_PW_CHK;
            phdl_pkg::ST_SR_RD:    state_next = phdl_pkg::ST_SR_CMP;
            phdl_pkg::ST_SR_CMP: begin
                if (tbl_rd_reg != pw_r_reg && (idx_reg + 1'b1) < f_reg)
                    state_next = phdl_pkg::ST_SR_RD;
                else
                    state_next = phdl_pkg::ST_DG_ACC;
            end
            phdl_pkg::ST_DG_ACC: begin
                if (digit_reg == '0) state_next = phdl_pkg::ST_DG_NEXT;
                else                 state_next = phdl_pkg::ST_PW_CHK;
            end
            phdl_pkg::ST_DG_H:     state_next = phdl_pkg::ST_PW_CHK;
            phdl_pkg::ST_DG_K:     state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_DG_Y:     state_next = phdl_pkg::ST_DG_NEXT;
            phdl_pkg::ST_DG_NEXT:  state_next = phdl_pkg::ST_DG_CHK;
            phdl_pkg::ST_CRT_REM:  state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_CRT_R1:   state_next = phdl_pkg::ST_INV_CHK;
            phdl_pkg::ST_INV_CHK:  state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_INV_Q:    state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_INV_T:    state_next = phdl_pkg::ST_INV_CHK;
            phdl_pkg::ST_CRT_V:    state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_CRT_TERM: state_next = phdl_pkg::ST_TD_CHK;
            phdl_pkg::ST_TD_END:   state_next = phdl_pkg::ST_FIN;
            phdl_pkg::ST_FIN: begin
                if (out_free) state_next = phdl_pkg::ST_IDLE;
            end
            phdl_pkg::ST_ALU_WAIT: begin
                if (alu_stat.done) state_next = ret_reg;
            end
            phdl_pkg::ST_PW_CHK: begin
                if (pw_e_reg == '0)   state_next = pw_ret_reg;
                else if (pw_e_reg[0]) state_next = phdl_pkg::ST_ALU_WAIT;
                else                  state_next = phdl_pkg::ST_PW_SQ;
            end
            phdl_pkg::ST_PW_MUL:   state_next = phdl_pkg::ST_PW_SQ;
            phdl_pkg::ST_PW_SQ:    state_next = phdl_pkg::ST_ALU_WAIT;
            phdl_pkg::ST_PW_SQD:   state_next = phdl_pkg::ST_PW_CHK;
            default:               state_next = phdl_pkg::ST_IDLE;
        endcase
    end

    // Datapath and unit control
    always_comb begin
        ret_next     = ret_reg;
        pw_ret_next  = pw_ret_reg;
        tgt_next     = tgt_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        b_next       = b_reg;
        y0_next      = y0_reg;
        y_next       = y_reg;
        rest_next    = rest_reg;
        f_next       = f_reg;
        cnt_next     = cnt_reg;
        dd_next      = dd_reg;
        dpow_next    = dpow_reg;
        dd1_next     = dd1_reg;
        acc_next     = acc_reg;
        g_next       = g_reg;
        tv_next      = tv_reg;
        idx_next     = idx_reg;
        digit_next   = digit_reg;
        miss_next    = miss_reg;
        x_next       = x_reg;
        rem_next     = rem_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        inv_next     = inv_reg;
        pw_r_next    = pw_r_reg;
        pw_s_next    = pw_s_reg;
        pw_e_next    = pw_e_reg;
        out_log_next = out_log_reg;
        out_st_next  = out_st_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_log_next   = m_log_reg;
        m_st_next    = m_st_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = idx_reg[AW-1:0];
        tbl_wdata    = alu_res;
        alu_req.start = 1'b0;
        alu_req.op    = phdl_pkg::ALU_MULMOD;
        alu_a        = '0;
        alu_b        = '0;
        alu_m        = p_reg;
        sum_x        = '0;
        t_diff       = '0;

        unique case (state_reg)
            phdl_pkg::ST_IDLE: begin
                if (accept) begin
                    tgt_next = s_target[VB-1:0];
                    p_next   = mod_cfg_reg;
                    n_next   = mod_cfg_reg - 1'b1;
                    if (mod_cfg_reg < VB'(3)) begin
                        out_log_next = '0;
                        out_st_next  = phdl_pkg::STAT_OK;
                    end else begin
                        // reduce the generator: 1 * b mod p
                        alu_req.start = 1'b1;
                        alu_a    = VB'(1);
                        alu_b    = gen_cfg_reg;
                        alu_m    = mod_cfg_reg;
                        ret_next = phdl_pkg::ST_RED_B;
                    end
                end
            end
            phdl_pkg::ST_RED_B: begin
                b_next = alu_res;
                alu_req.start = 1'b1;
                alu_a    = VB'(1);
                alu_b    = tgt_reg;
                ret_next = phdl_pkg::ST_RED_Y;
            end
            phdl_pkg::ST_RED_Y: begin
                y0_next   = alu_res;
                rest_next = n_reg;
                f_next    = FB'(2);
                x_next    = '0;
                cnt_next  = '0;
                miss_next = 1'b0;
            end
            phdl_pkg::ST_TD_CHK: begin
                if (!(f_reg > FB'(MAX_PRIME) || rest_reg <= VB'(1))) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = phdl_pkg::ALU_DIV;
                    alu_a    = '0;
                    alu_b    = rest_reg;
                    alu_m    = VB'(f_reg);
                    ret_next = phdl_pkg::ST_TD_FIRST;
                end
            end
            phdl_pkg::ST_TD_FIRST: begin
                if (alu_res != '0) begin
                    f_next = f_reg + 1'b1;
                end else if (cnt_reg >= CB'(MAX_FACTORS)) begin
                    out_log_next = '0;
                    out_st_next  = phdl_pkg::STAT_BOUND;
                end else begin
                    rest_next = alu_quo;
                    dd_next   = VB'(f_reg);
                    cnt_next  = cnt_reg + 1'b1;
                    alu_req.start = 1'b1;
                    alu_req.op    = phdl_pkg::ALU_DIV;
                    alu_b    = alu_quo;
                    alu_m    = VB'(f_reg);
                    ret_next = phdl_pkg::ST_TD_MORE;
                end
            end
            phdl_pkg::ST_TD_MORE: begin
                if (alu_res == '0) begin
                    rest_next = alu_quo;
                    dd_next   = dd_reg * VB'(f_reg);
                    alu_req.start = 1'b1;
                    alu_req.op    = phdl_pkg::ALU_DIV;
                    alu_b    = alu_quo;
                    alu_m    = VB'(f_reg);
                    ret_next = phdl_pkg::ST_TD_MORE;
                end
            end
            phdl_pkg::ST_FAC: begin
                alu_req.start = 1'b1;
                alu_req.op    = phdl_pkg::ALU_DIV;
                alu_b    = n_reg;
                alu_m    = VB'(f_reg);
                ret_next = phdl_pkg::ST_G;
            end
            phdl_pkg::ST_G: begin
                // g = b^(n/d)
                pw_r_next   = VB'(1);
                pw_s_next   = b_reg;
                pw_e_next   = alu_quo;
                pw_ret_next = phdl_pkg::ST_TBL0;
            end
            phdl_pkg::ST_TBL0: begin
                g_next    = pw_r_reg;
                tv_next   = VB'(1);
                tbl_we    = 1'b1;
                tbl_waddr = '0;
                tbl_wdata = VB'(1);
                idx_next  = FB'(1);
            end
            phdl_pkg::ST_TBL: begin
                if (idx_reg < f_reg) begin
                    alu_req.start = 1'b1;
                    alu_a    = tv_reg;
                    alu_b    = g_reg;
                    ret_next = phdl_pkg::ST_TBL_W;
                end else begin
                    y_next    = y0_reg;
                    acc_next  = '0;
                    dpow_next = VB'(1);
                end
            end
            phdl_pkg::ST_TBL_W: begin
                tv_next  = alu_res;
                tbl_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            phdl_pkg::ST_DG_CHK: begin
                if (dpow_reg == dd_reg) begin
                    // all digits found: start the CRT term, rem = n / d^e
                    alu_req.start = 1'b1;
                    alu_req.op    = phdl_pkg::ALU_DIV;
                    alu_b    = n_reg;
                    alu_m    = dd_reg;
                    ret_next = phdl_pkg::ST_CRT_REM;
                end else begin
                    dd1_next = dpow_reg * VB'(f_reg);
                end
            end
            phdl_pkg::ST_DG_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = phdl_pkg::ALU_DIV;
                alu_b    = n_reg;
                alu_m    = dd1_reg;
                ret_next = phdl_pkg::ST_DG_PROBE;
            end
            phdl_pkg::ST_DG_PROBE: begin
                pw_r_next   = VB'(1);
                pw_s_next   = y_reg;
                pw_e_next   = alu_quo;
                pw_ret_next = phdl_pkg::ST_SR_RD;
                idx_next    = '0;
            end
            phdl_pkg::ST_SR_RD: ;
            phdl_pkg::ST_SR_CMP: begin
                // probe sits in pw_r; first match wins, no match means digit 1
                if (tbl_rd_reg == pw_r_reg) begin
                    digit_next = idx_reg;
                end else if ((idx_reg + 1'b1) < f_reg) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    digit_next = FB'(1);
                    miss_next  = 1'b1;
                end
            end
            phdl_pkg::ST_DG_ACC: begin
                acc_next = acc_reg + dpow_reg * VB'(digit_reg);
                if (digit_reg != '0) begin
                    pw_r_next   = VB'(1);
                    pw_s_next   = b_reg;
                    pw_e_next   = dpow_reg;
                    pw_ret_next = phdl_pkg::ST_DG_H;
                end
            end
            phdl_pkg::ST_DG_H: begin
                // (b^dpow)^(n - digit)
                pw_r_next   = VB'(1);
                pw_s_next   = pw_r_reg;
                pw_e_next   = n_reg - VB'(digit_reg);
                pw_ret_next = phdl_pkg::ST_DG_K;
            end
            phdl_pkg::ST_DG_K: begin
                alu_req.start = 1'b1;
                alu_a    = y_reg;
                alu_b    = pw_r_reg;
                ret_next = phdl_pkg::ST_DG_Y;
            end
            phdl_pkg::ST_DG_Y: begin
                y_next = alu_res;
            end
            phdl_pkg::ST_DG_NEXT: begin
                dpow_next = dd1_reg;
            end
            phdl_pkg::ST_CRT_REM: begin
                rem_next = alu_quo;
                alu_req.start = 1'b1;
                alu_req.op    = phdl_pkg::ALU_DIV;
                alu_b    = alu_quo;
                alu_m    = dd_reg;
                ret_next = phdl_pkg::ST_CRT_R1;
            end
            phdl_pkg::ST_CRT_R1: begin
                r1_next = alu_res;
                r0_next = dd_reg;
                t0_next = '0;
                t1_next = VB'(1);
            end
            phdl_pkg::ST_INV_CHK: begin
                if (r1_reg == '0) begin
                    inv_next = (r0_reg == VB'(1)) ? t0_reg : '0;
                    alu_req.start = 1'b1;
                    alu_a    = acc_reg;
                    alu_b    = rem_reg;
                    alu_m    = n_reg;
                    ret_next = phdl_pkg::ST_CRT_V;
                end else begin
                    alu_req.start = 1'b1;
                    alu_req.op    = phdl_pkg::ALU_DIV;
                    alu_b    = r0_reg;
                    alu_m    = r1_reg;
                    ret_next = phdl_pkg::ST_INV_Q;
                end
            end
            phdl_pkg::ST_INV_Q: begin
                r0_next = r1_reg;
                r1_next = alu_res;
                // q * t1 mod d^e
                alu_req.start = 1'b1;
                alu_a    = t1_reg;
                alu_b    = alu_quo;
                alu_m    = dd_reg;
                ret_next = phdl_pkg::ST_INV_T;
            end
            phdl_pkg::ST_INV_T: begin
                t_diff  = {1'b0, t0_reg} + {1'b0, dd_reg} - {1'b0, alu_res};
                t0_next = t1_reg;
                t1_next = (t0_reg >= alu_res) ? (t0_reg - alu_res) : t_diff[VB-1:0];
            end
            phdl_pkg::ST_CRT_V: begin
                alu_req.start = 1'b1;
                alu_a    = alu_res;
                alu_b    = inv_reg;
                alu_m    = n_reg;
                ret_next = phdl_pkg::ST_CRT_TERM;
            end
            phdl_pkg::ST_CRT_TERM: begin
                sum_x  = {1'b0, x_reg} + {1'b0, alu_res};
                x_next = (sum_x >= {1'b0, n_reg}) ? VB'(sum_x - {1'b0, n_reg})
                                                  : sum_x[VB-1:0];
                f_next = f_reg + 1'b1;
            end
            phdl_pkg::ST_TD_END: begin
                if (rest_reg > VB'(1)) begin
                    out_log_next = '0;
                    out_st_next  = phdl_pkg::STAT_BOUND;
                end else begin
                    out_log_next = x_reg;
                    out_st_next  = miss_reg ? phdl_pkg::STAT_NODIGIT : phdl_pkg::STAT_OK;
                end
            end
            phdl_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_log_next   = out_log_reg;
                    m_st_next    = out_st_reg;
                end
            end
            phdl_pkg::ST_ALU_WAIT: ;
            phdl_pkg::ST_PW_CHK: begin
                if (pw_e_reg != '0 && pw_e_reg[0]) begin
                    alu_req.start = 1'b1;
                    alu_a    = pw_r_reg;
                    alu_b    = pw_s_reg;
                    ret_next = phdl_pkg::ST_PW_MUL;
                end
            end
            phdl_pkg::ST_PW_MUL: begin
                pw_r_next = alu_res;
            end
            phdl_pkg::ST_PW_SQ: begin
                alu_req.start = 1'b1;
                alu_a    = pw_s_reg;
                alu_b    = pw_s_reg;
                ret_next = phdl_pkg::ST_PW_SQD;
            end
            phdl_pkg::ST_PW_SQD: begin
                pw_s_next = alu_res;
                pw_e_next = {1'b0, pw_e_reg[VB-1:1]};
            end
            default: ;
        endcase
    end

    // Digit table: write port from the sequencer, registered read at the search index
    always_ff @(posedge aclk) begin
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
        tbl_rd_reg <= tbl_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= phdl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        pw_ret_reg  <= pw_ret_next;
        tgt_reg     <= tgt_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        b_reg       <= b_next;
        y0_reg      <= y0_next;
        y_reg       <= y_next;
        rest_reg    <= rest_next;
        f_reg       <= f_next;
        cnt_reg     <= cnt_next;
        dd_reg      <= dd_next;
        dpow_reg    <= dpow_next;
        dd1_reg     <= dd1_next;
        acc_reg     <= acc_next;
        g_reg       <= g_next;
        tv_reg      <= tv_next;
        idx_reg     <= idx_next;
        digit_reg   <= digit_next;
        miss_reg    <= miss_next;
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        inv_reg     <= inv_next;
        pw_r_reg    <= pw_r_next;
        pw_s_reg    <= pw_s_next;
        pw_e_reg    <= pw_e_next;
        out_log_reg <= out_log_next;
        out_st_reg  <= out_st_next;
        m_log_reg   <= m_log_next;
        m_st_reg    <= m_st_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_log_value = phdl_pkg::LOG_BITS'(m_log_reg);
    assign m_status    = m_st_reg;

    // Never start the shared unit while it is still working
    `PHDL_ASSERT(a_alu_start_idle, aclk, aresetn, alu_req.start |-> !alu_stat.busy, "unit started while busy")
    // A bound failure always reports a zero exponent
    `PHDL_ASSERT(a_bound_zero, aclk, aresetn, (m_valid && m_status == phdl_pkg::STAT_BOUND) |-> (m_log_value == '0), "bound status with nonzero log")
    // Taking a new word only happens with the unit quiet
    `PHDL_ASSERT(a_idle_quiet, aclk, aresetn, s_ready |-> !alu_stat.busy, "input taken while unit busy")

endmodule
`default_nettype wire
